[rtl/core/b2p_pkg.sv]
// ----------------------------------------------------------------------------
// b2p_pkg
// Shared types and constants for the 4bpp bitmap to planar converter.
// ----------------------------------------------------------------------------
package b2p_pkg;

   // Control register map, indexed by csr_paddr[3:2].
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_SCAN_PITCH   = 2'd2
   } csr_reg_type;

   // Register reset values.
   localparam logic [9:0] IMAGE_WIDTH_RESET  = 10'd640;
   localparam logic [9:0] IMAGE_HEIGHT_RESET = 10'd480;
   localparam logic [7:0] SCAN_PITCH_RESET   = 8'd80;

   // Field widths.
   localparam int unsigned COL_W    = 9;
   localparam int unsigned ROW_W    = 10;
   localparam int unsigned OFFSET_W = 18;
   localparam int unsigned RSP_DATA_W = 56;

   // Four plane bytes of one group of eight pixels.
   typedef logic [3:0][7:0] planes_type;

endpackage

[rtl/core/bmp4_to_planar_converter.sv]
// ----------------------------------------------------------------------------
// bmp4_to_planar_converter
// Converts a bottom-up 4bpp bitmap byte stream into planar framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one bitmap data byte per transfer; req_tuser is
//   high on the first byte of an image and restarts all counters. Each byte
//   holds two pixels, high nibble first; row padding bytes are consumed.
//   The rsp channel carries one framebuffer write per complete group of eight
//   pixels or per row end: the byte offset and four plane bytes. rsp_tlast
//   marks the final write of the image. Bytes after the last row are dropped.
//   The csr port holds image width, image height and line length; write it
//   only while no transfer is in flight.
// Timing:
//   One byte per cycle sustained while rsp does not stall. A byte enters an
//   input register and is processed from there into the output register,
//   which drives rsp. The next counter state is computed combinationally and
//   registered with each processed byte, which sets the rate of one byte per
//   clock.
//   Reset clears both registers, the counters and the plane accumulators and
//   loads the default geometry. When rsp stalls with a write pending, the
//   input register still fills once and then req_tready drops.
// ----------------------------------------------------------------------------
module bmp4_to_planar_converter #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_byte
   input  logic        req_tuser,   // [0] start_of_image
   // Framebuffer write stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [17:0] fb_offset, [25:18] plane_zero,
                                    // [33:26] plane_one, [41:34] plane_two,
                                    // [49:42] plane_three, [55:50] zero
   output logic        rsp_tlast,   // image_done
   // Control registers.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import b2p_pkg::*;

   // Control registers.
   logic [9:0] width_ff;
   logic [9:0] height_ff;
   logic [7:0] line_len_ff;
   logic       csr_write;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_sof_ff;

   // Stream state.
   logic [COL_W-1:0] byte_column_ff, byte_column_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   planes_type       accum_ff, accum_in;
   logic             finished_ff, finished_in;

   // Output register.
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_last_ff, out_last_in;

   // Processing signals.
   logic             out_free;
   logic             advance;
   logic [9:0]       w_eff;
   logic [9:0]       h_eff;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   planes_type       acc;
   planes_type       acc_new;
   logic             fin;
   logic             active;
   logic [9:0]       data_bytes;
   logic [9:0]       row_bytes;
   logic             in_data;
   logic [9:0]       px0;
   logic [9:0]       px1;
   logic             px1_ok;
   logic [9:0]       last_px;
   logic             row_end;
   logic             emit;
   logic             col_wrap;
   logic [9:0]       flipped;
   logic [OFFSET_W-1:0] offset;
   logic [2:0]       pos0;
   logic [2:0]       pos1;

   // APB register access; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= IMAGE_WIDTH_RESET;
         height_ff   <= IMAGE_HEIGHT_RESET;
         line_len_ff <= SCAN_PITCH_RESET;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_paddr[3:2]))
            REG_IMAGE_WIDTH:  width_ff    <= csr_pwdata[9:0];
            REG_IMAGE_HEIGHT: height_ff   <= csr_pwdata[9:0];
            REG_SCAN_PITCH:   line_len_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[3:2]))
         REG_IMAGE_WIDTH:  csr_prdata = {22'd0, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {22'd0, height_ff};
         REG_SCAN_PITCH:   csr_prdata = {24'd0, line_len_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // Handshake: the input register moves on whenever the output register is free.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_sof_ff  <= req_tuser;
      end
   end

   // Geometry, clipped to the supported maximum.
   always_comb begin
      w_eff = (32'(width_ff) > MAX_WIDTH) ? 10'(MAX_WIDTH) : width_ff;
      h_eff = (32'(height_ff) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : height_ff;
      data_bytes = 10'(({1'b0, w_eff} + 11'd1) >> 1);
      row_bytes  = (data_bytes + 10'd3) & ~10'd3;
   end

   // Per-byte processing: pixel placement, write decision and next state.
   always_comb begin
      // A start-of-image byte sees cleared state.
      col = in_sof_ff ? '0 : byte_column_ff;
      row = in_sof_ff ? '0 : row_count_ff;
      acc = in_sof_ff ? '0 : accum_ff;
      fin = in_sof_ff ? 1'b0 : finished_ff;

      active  = (w_eff != 10'd0) && (h_eff != 10'd0) && !fin && (row < h_eff);
      in_data = {1'b0, col} < data_bytes;

      px0     = {col, 1'b0};
      px1     = px0 | 10'd1;
      px1_ok  = px1 < w_eff;
      last_px = px1_ok ? px1 : px0;
      row_end = last_px == (w_eff - 10'd1);
      pos0    = 3'd7 - px0[2:0];
      pos1    = 3'd7 - px1[2:0];

      // Spread colour bit k of both pixels into plane k.
      acc_new = acc;
      for (int k = 0; k < 4; k++) begin
         acc_new[k][pos0] = acc[k][pos0] | in_byte_ff[4 + k];
         acc_new[k][pos1] = acc[k][pos1] | (px1_ok & in_byte_ff[k]);
      end

      emit     = active && in_data && (row_end || (last_px[2:0] == 3'b111));
      col_wrap = ({1'b0, col} + 10'd1) >= row_bytes;

      // Offset: flipped row times line length plus byte column, low bits kept.
      flipped = h_eff - 10'd1 - row;
      offset  = OFFSET_W'(OFFSET_W'(flipped) * OFFSET_W'(line_len_ff)
                          + OFFSET_W'(last_px[9:3]));

      out_data_in = {6'd0, acc_new[3], acc_new[2], acc_new[1], acc_new[0], offset};
      out_last_in = row_end && (row == (h_eff - 10'd1));

      // Next state.
      byte_column_in = col;
      row_count_in   = row;
      accum_in       = acc;
      finished_in    = fin;
      if (active) begin
         if (col_wrap) begin
            byte_column_in = '0;
            accum_in       = '0;
            finished_in    = ({1'b0, row} + 11'd1) >= {1'b0, h_eff};
            row_count_in   = row + 10'd1;
         end else begin
            byte_column_in = col + 9'd1;
            if (emit) begin
               accum_in = '0;
            end else if (in_data) begin
               accum_in = acc_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_column_ff <= '0;
         row_count_ff   <= '0;
         accum_ff       <= '0;
         finished_ff    <= 1'b0;
      end else if (advance) begin
         byte_column_ff <= byte_column_in;
         row_count_ff   <= row_count_in;
         accum_ff       <= accum_in;
         finished_ff    <= finished_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // A finished image leaves no partial group behind.
   a_finished_clear : assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> (accum_ff == '0))
      else $error("plane accumulator not clear after image end");

   // A partial group exists only inside a row, never at its first column.
   a_partial_mid_row : assert property (@(posedge clock) disable iff (reset)
      (accum_ff != '0) |-> (byte_column_ff != '0))
      else $error("partial group held at column zero");

   // Every processed write reaches the output register.
   a_emit_valid : assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> rsp_tvalid)
      else $error("write lost between stages");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4bpp bitmap to planar converter.
// ----------------------------------------------------------------------------
// Bitmap bytes go into the req stream with random gaps. A model of the
// converter runs inside the bench and predicts every framebuffer write. A
// monitor on the rsp stream compares each write, field by field, with the
// oldest prediction. The rsp side stalls at random, and once holds off for a
// long stretch so that the converter backs up into req. The geometry
// registers are written over the APB port and read back between images. The
// directed tests cover the reset geometry, odd widths, padding, restarts,
// zero sizes, the largest sizes and reconfiguration in the middle of an image.
// The random images that follow are mostly complete, with some cut short.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import b2p_pkg::*;

   // Cycles for a byte to pass the input and output registers, with margin.
   localparam int unsigned SETTLE_CYCLES = 4;
   // Longest wait for outstanding writes before they count as lost.
   localparam int unsigned DRAIN_LIMIT = 2000;
   localparam int unsigned MAX_GAP = 18;
   localparam int unsigned RANDOM_TARGET = 450;
   localparam int unsigned HOLD_OFF_CYCLES = 300;

   // One framebuffer write as it leaves the converter.
   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      planes_type          planes;
      logic                done;
   } fb_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] pixel_byte
   logic        req_tuser = 1'b0;  // [0] start_of_image
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // [17:0] fb_offset, [25:18] plane_zero,
                                   // [33:26] plane_one, [41:34] plane_two,
                                   // [49:42] plane_three, [55:50] zero
   logic        rsp_tlast;         // [0] image_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Geometry as the converter should hold it.
   logic [9:0] geo_width  = IMAGE_WIDTH_RESET;
   logic [9:0] geo_height = IMAGE_HEIGHT_RESET;
   logic [7:0] geo_line   = SCAN_PITCH_RESET;

   // Conversion state of the bench's own converter model.
   logic [COL_W-1:0] cur_column = '0;
   logic [ROW_W-1:0] cur_row = '0;
   planes_type       accum = '0;
   bit               image_finished = 1'b0;

   fb_write_type pending_writes[$];

   // Flow control of both streams.
   bit          sender_burst = 1'b0;
   bit          rsp_burst = 1'b0;
   int unsigned hold_request = 0;
   int unsigned stall_left = 0;

   // Run statistics.
   int unsigned error_count = 0;
   int unsigned sent_bytes = 0;
   int unsigned used_bytes = 0;
   int unsigned writes_checked = 0;
   int unsigned images_started = 0;
   int unsigned config_writes = 0;

   string plane_names[4] = '{"plane_zero", "plane_one", "plane_two", "plane_three"};

   bmp4_to_planar_converter dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Time limit for a run that hangs.
   initial begin
      #20ms;
      $display("Timeout: the run did not complete in time.");
      $display("** bmp4_to_planar_converter: FAILED **");
      $finish;
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void compare_field(input string field_name,
                                         input logic [31:0] expected_value,
                                         input logic [31:0] actual_value);
      if (actual_value !== expected_value) begin
         note_error($sformatf("%s expected 0x%0h, got 0x%0h",
                              field_name, expected_value, actual_value));
      end
   endfunction

   function automatic int unsigned draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Bytes of one whole image: rows padded to four bytes.
   function automatic int unsigned image_bytes();
      int unsigned data_bytes;
      data_bytes = (geo_width + 1) / 2;
      return ((data_bytes + 3) & ~32'd3) * geo_height;
   endfunction

   // Model of the converter for one accepted byte. Queues the write that the
   // byte completes and returns whether the byte took effect at all.
   function automatic bit convert_byte(input logic [7:0] pixel, input logic first);
      int unsigned w, h, data_bytes, row_bytes, px, last_px, addr, n, k;
      logic [3:0] nibble;
      bit row_end;
      fb_write_type wr;
      w = geo_width;
      h = geo_height;
      if (first) begin
         cur_column = '0;
         cur_row = '0;
         accum = '0;
         image_finished = 1'b0;
      end
      if (w == 0 || h == 0 || image_finished || cur_row >= h) begin
         return 1'b0;
      end
      data_bytes = (w + 1) / 2;
      row_bytes = (data_bytes + 3) & ~32'd3;

      // Pixel bytes spread their nibbles over the planes; padding does not.
      if (cur_column < data_bytes) begin
         px = 2 * cur_column;
         last_px = px;
         for (n = 0; n < 2; n++) begin
            if (px + n < w) begin
               nibble = (n == 0) ? pixel[7:4] : pixel[3:0];
               for (k = 0; k < 4; k++) begin
                  if (nibble[k]) begin
                     accum[k][7 - ((px + n) & 7)] = 1'b1;
                  end
               end
               last_px = px + n;
            end
         end
         row_end = (last_px == w - 1);
         if (row_end || (last_px & 7) == 7) begin
            addr = (h - 1 - cur_row) * geo_line + (last_px >> 3);
            wr.offset = addr[OFFSET_W-1:0];
            wr.planes = accum;
            wr.done = row_end && (cur_row == h - 1);
            pending_writes.push_back(wr);
            accum = '0;
         end
      end

      // Advance the column, or close the row at the padded row length.
      if (cur_column + 1 >= row_bytes) begin
         cur_column = '0;
         accum = '0;
         if (cur_row + 1 >= h) begin
            image_finished = 1'b1;
         end
         cur_row = cur_row + 1'b1;
      end else begin
         cur_column = cur_column + 1'b1;
      end
      return 1'b1;
   endfunction

   // Receiver: stalls for a drawn number of cycles after each transfer, or
   // for a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (rsp_tvalid && rsp_tready) begin
            stall_left = draw_gap(rsp_burst);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Each write transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      fb_write_type want;
      int k;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            note_error($sformatf("unexpected write, tdata 0x%0h tlast %0b",
                                 rsp_tdata, rsp_tlast));
         end else begin
            want = pending_writes.pop_front();
            compare_field("fb_offset", 32'(want.offset), 32'(rsp_tdata[17:0]));
            for (k = 0; k < 4; k++) begin
               compare_field(plane_names[k], 32'(want.planes[k]),
                             32'(rsp_tdata[18 + 8*k +: 8]));
            end
            compare_field("tdata pad", 32'd0, 32'(rsp_tdata[55:50]));
            compare_field("image_done", 32'(want.done), 32'(rsp_tlast));
            writes_checked++;
         end
      end
   end

   // Sends one bitmap byte and predicts its effect once it is accepted.
   task automatic send_byte(input logic [7:0] pixel, input logic first);
      int unsigned gap;
      gap = draw_gap(sender_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pixel;
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      sent_bytes++;
      if (first) begin
         images_started++;
      end
      if (convert_byte(pixel, first)) begin
         used_bytes++;
      end
   endtask

   // Stops the byte stream and waits until every predicted write has come.
   task automatic wait_for_idle();
      int unsigned waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_writes.size() != 0) begin
         note_error($sformatf("%0d expected writes never arrived", pending_writes.size()));
         pending_writes.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup, access, then back to idle.
   task automatic csr_access(input bit write, input csr_reg_type reg_index,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type reg_index, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(1'b1, reg_index, value, unused);
      case (reg_index)
         REG_IMAGE_WIDTH: geo_width = value[9:0];
         REG_IMAGE_HEIGHT: geo_height = value[9:0];
         REG_SCAN_PITCH: geo_line = value[7:0];
         default: ;
      endcase
      config_writes++;
   endtask

   task automatic read_back_registers();
      logic [31:0] value;
      csr_access(1'b0, REG_IMAGE_WIDTH, '0, value);
      compare_field("image_width readback", {22'd0, geo_width}, value);
      csr_access(1'b0, REG_IMAGE_HEIGHT, '0, value);
      compare_field("image_height readback", {22'd0, geo_height}, value);
      csr_access(1'b0, REG_SCAN_PITCH, '0, value);
      compare_field("scan pitch readback", {24'd0, geo_line}, value);
   endtask

   task automatic apply_geometry(input int unsigned w, input int unsigned h,
                                 input int unsigned ll);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_SCAN_PITCH, ll);
      read_back_registers();
   endtask

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Sends an image for the current geometry, whole or cut short; after a whole
   // image, up to two stray bytes that the converter must drop.
   task automatic send_image(input bit broken);
      int unsigned total, i;
      total = image_bytes();
      if (total == 0) begin
         total = 4;
      end
      if (broken) begin
         total = $urandom_range(1, total);
      end
      for (i = 0; i < total; i++) begin
         send_byte(random_pixel(), i == 0);
      end
      if (!broken) begin
         repeat ($urandom_range(0, 2)) send_byte(random_pixel(), 1'b0);
      end
   endtask

   // The reset geometry of 640 by 480 with 80-byte lines.
   task automatic test_default_geometry();
      send_byte(8'h12, 1'b1);
      repeat (15) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
   endtask

   // Reset values read back, then every register at its largest value.
   task automatic test_register_access();
      read_back_registers();
      apply_geometry(1023, 1023, 255);
   endtask

   // Odd width with a half-used byte, padding, trailing bytes, zero line
   // length and a restart in the middle of a row.
   task automatic test_directed_corners();
      apply_geometry(3, 2, 255);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h0F, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'hCC, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h81, 1'b0);
      wait_for_idle();
      apply_geometry(16, 2, 0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h18, 1'b0);
      send_byte(8'h7E, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hE7, 1'b0);
      send_byte(8'h42, 1'b0);
      wait_for_idle();
   endtask

   // Zero width or zero height: every byte is dropped.
   task automatic test_zero_geometry();
      apply_geometry(0, 5, 10);
      send_byte(8'hFF, 1'b1);
      repeat (4) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
      apply_geometry(8, 0, 10);
      send_byte(8'hFF, 1'b1);
      repeat (4) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
   endtask

   // The start of the widest row, then the first rows of the tallest image,
   // which carry the largest offsets.
   task automatic test_extreme_geometry();
      apply_geometry(1023, 1, 255);
      send_byte(random_pixel(), 1'b1);
      repeat (47) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
      apply_geometry(1, 1023, 255);
      send_byte(random_pixel(), 1'b1);
      repeat (23) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
   endtask

   // Geometry changed while an image is half done: a column past the new
   // row length closes the row, a row past the new height ends the image.
   task automatic test_reconfig_mid_image();
      apply_geometry(24, 3, 40);
      send_byte(random_pixel(), 1'b1);
      repeat (19) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
      csr_write(REG_IMAGE_WIDTH, 7);
      repeat (10) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
      csr_write(REG_IMAGE_HEIGHT, 1);
      repeat (3) send_byte(random_pixel(), 1'b0);
      wait_for_idle();
   endtask

   // The receiver holds off while bytes keep coming, so req must stall.
   task automatic test_backpressure();
      apply_geometry(32, 4, 100);
      sender_burst = 1'b1;
      hold_request = HOLD_OFF_CYCLES;
      send_byte(random_pixel(), 1'b1);
      repeat (63) send_byte(random_pixel(), 1'b0);
      sender_burst = 1'b0;
      wait_for_idle();
   endtask

   // Random geometries and images, mostly complete, some cut short.
   task automatic test_random_images();
      int unsigned start_used, image_index, w, h, ll, pick;
      start_used = used_bytes;
      image_index = 0;
      while (used_bytes - start_used < RANDOM_TARGET) begin
         if (image_index % 5 == 0) begin
            wait_for_idle();
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               w = $urandom_range(200, 400);
               h = 1;
            end else if (pick < 4) begin
               w = $urandom_range(41, 200);
               h = $urandom_range(1, 3);
            end else begin
               w = $urandom_range(1, 40);
               h = $urandom_range(1, 6);
            end
            case ($urandom_range(0, 9))
               0: ll = 0;
               1: ll = 255;
               2: ll = 1;
               default: ll = $urandom_range(0, 255);
            endcase
            apply_geometry(w, h, ll);
         end
         sender_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         send_image($urandom_range(0, 6) == 0);
         image_index++;
      end
      sender_burst = 1'b0;
      rsp_burst = 1'b0;
      wait_for_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_geometry();
      test_register_access();
      test_directed_corners();
      test_zero_geometry();
      test_extreme_geometry();
      test_reconfig_mid_image();
      test_backpressure();
      test_random_images();
      wait_for_idle();
      $display("Covered %0d images: %0d bytes sent, %0d converted, %0d plane writes checked.",
               images_started, sent_bytes, used_bytes, writes_checked);
      $display("Geometry changed by %0d register writes, sizes from zero to the maximum.",
               config_writes);
      if (error_count == 0) begin
         $display("** bmp4_to_planar_converter: PASSED **");
      end else begin
         $display("%0d mismatches in total.", error_count);
         $display("** bmp4_to_planar_converter: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/b2p_pkg.sv
rtl/core/bmp4_to_planar_converter.sv
verif/testbench.sv
